// ----- rtl/ordered_list_engine_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Ordered list engine assertion macros
// Shared concurrent assertion forms, clocked on clk and gated by rst_n.
// ----------------------------------------------------------------------------
`ifndef ORDERED_LIST_ENGINE_UNIT_MACROS_SVH
`define ORDERED_LIST_ENGINE_UNIT_MACROS_SVH

// same-cycle implication
`define OLLE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ordered list engine: same-cycle check failed");

// next-cycle implication
`define OLLE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ordered list engine: next-cycle check failed");

`endif

// ----- rtl/olle_pkg.sv -----
// ----------------------------------------------------------------------------
// Ordered list engine package
// Widths, operation and status codes, and the per-cell control word.
// ----------------------------------------------------------------------------
package olle_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int VAL_W     = 32;

  typedef enum logic [1:0] {
    FN_INSERT   = 2'd0,
    FN_DELETE   = 2'd1,
    FN_TRAVERSE = 2'd2,
    FN_CLEAR    = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  typedef struct packed {
    logic load;   // write the request value into the addressed cell
    logic shift;  // rotate the ring one place toward the head
  } cell_ctrl_t;

endpackage

// ----- rtl/olle_cell.sv -----
// ----------------------------------------------------------------------------
// Ordered list engine cell
// Holds one list entry; loads a new value when addressed, otherwise takes
// its neighbor's value on a shift, or the head value when it is the tail.
// ----------------------------------------------------------------------------
module olle_cell #(
  parameter int DEPTH    = olle_pkg::DEPTH_DEF,
  parameter int CELL_IDX = 0,
  localparam int IDX_W   = $clog2(DEPTH)
) (
  input  logic                               clk,
  input  olle_pkg::cell_ctrl_t               ctrl,
  input  logic [IDX_W-1:0]                   load_idx,
  input  logic [IDX_W-1:0]                   tail_idx,
  input  logic signed [olle_pkg::VAL_W-1:0]  load_val,
  input  logic signed [olle_pkg::VAL_W-1:0]  next_val,
  input  logic signed [olle_pkg::VAL_W-1:0]  head_val,
  output logic signed [olle_pkg::VAL_W-1:0]  val
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic signed [olle_pkg::VAL_W-1:0] val_r;
  logic signed [olle_pkg::VAL_W-1:0] val_nxt;

  always_comb begin
    val_nxt = val_r;
    if (ctrl.load && (load_idx == MY_IDX)) begin
      val_nxt = load_val;
    end else if (ctrl.shift) begin
      val_nxt = (tail_idx == MY_IDX) ? head_val : next_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;

endmodule

// ----- rtl/ordered_list_engine_unit.sv -----
// ----------------------------------------------------------------------------
// Ordered list engine
// Ordered list of up to DEPTH signed values held in a ring of cells, with
// insert at tail, delete of first match, traverse and clear.
// ----------------------------------------------------------------------------
// channel | ports                                   | handshake
// --------+-----------------------------------------+-------------------------
// input   | in_func, in_value                       | start high, busy low
// result  | out_item_value, out_status, out_last    | out_valid, one cycle
//
// Insert, clear and any request on an empty list: result on the next cycle,
// busy stays low. Delete and traverse on a list of n entries rotate the
// cell ring once around with busy high; traverse gives one beat per cycle,
// delete one beat at the end. Reset empties the list; cell contents are not
// cleared. No stalls: results are dropped if not taken.
// ----------------------------------------------------------------------------
`include "ordered_list_engine_unit_macros.svh"

module ordered_list_engine_unit #(
  parameter int DEPTH = olle_pkg::DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         in_func,
  input  logic signed [olle_pkg::VAL_W-1:0]  in_value,
  output logic                               out_valid,
  output logic signed [olle_pkg::VAL_W-1:0]  out_item_value,
  output logic [1:0]                         out_status,
  output logic                               out_last
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] ONE_CNT  = CNT_W'(1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } state_t;

  state_t                            state_r,  state_nxt;
  logic [CNT_W-1:0]                  count_r,  count_nxt;
  logic [CNT_W-1:0]                  steps_r,  steps_nxt;
  olle_pkg::func_t                   op_r,     op_nxt;
  logic signed [olle_pkg::VAL_W-1:0] key_r,    key_nxt;
  logic                              found_r,  found_nxt;
  logic                              ovld_r,   ovld_nxt;
  logic signed [olle_pkg::VAL_W-1:0] oitem_r,  oitem_nxt;
  olle_pkg::status_t                 ostat_r,  ostat_nxt;
  logic                              olast_r,  olast_nxt;

  olle_pkg::cell_ctrl_t              ctrl;
  logic [IDX_W-1:0]                  tail_idx;
  logic [CNT_W-1:0]                  count_m1;
  logic                              accept;
  logic                              hit;
  olle_pkg::func_t                   func_in;
  logic signed [olle_pkg::VAL_W-1:0] cell_val [DEPTH];

  assign func_in  = olle_pkg::func_t'(in_func);
  assign accept   = start && (state_r == S_IDLE);
  assign count_m1 = count_r - ONE_CNT;
  assign tail_idx = count_m1[IDX_W-1:0];
  assign hit      = (state_r == S_RUN) && (op_r == olle_pkg::FN_DELETE) &&
                    !found_r && (cell_val[0] == key_r);

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    steps_nxt  = steps_r;
    op_nxt     = op_r;
    key_nxt    = key_r;
    found_nxt  = found_r;
    ovld_nxt   = 1'b0;
    oitem_nxt  = '0;
    ostat_nxt  = olle_pkg::ST_OK;
    olast_nxt  = 1'b1;
    ctrl.load  = 1'b0;
    ctrl.shift = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          ovld_nxt  = 1'b1;
          op_nxt    = func_in;
          key_nxt   = in_value;
          found_nxt = 1'b0;
          steps_nxt = count_r;
          unique case (func_in)
            olle_pkg::FN_INSERT: begin
              if (count_r == FULL_CNT) begin
                ostat_nxt = olle_pkg::ST_FULL;
              end else begin
                ctrl.load = 1'b1;
                count_nxt = count_r + ONE_CNT;
              end
            end
            olle_pkg::FN_DELETE,
            olle_pkg::FN_TRAVERSE: begin
              if (count_r == '0) begin
                ostat_nxt = olle_pkg::ST_EMPTY;
              end else begin
                ovld_nxt  = 1'b0;
                state_nxt = S_RUN;
              end
            end
            olle_pkg::FN_CLEAR: begin
              count_nxt = '0;
            end
            default: ;
          endcase
        end
      end
      S_RUN: begin
        ctrl.shift = 1'b1;
        steps_nxt  = steps_r - ONE_CNT;
        if (hit) begin
          found_nxt = 1'b1;
          count_nxt = count_m1;
        end
        if (op_r == olle_pkg::FN_TRAVERSE) begin
          ovld_nxt  = 1'b1;
          oitem_nxt = cell_val[0];
          olast_nxt = (steps_r == ONE_CNT);
        end else if (steps_r == ONE_CNT) begin
          ovld_nxt  = 1'b1;
          ostat_nxt = (found_r || hit) ? olle_pkg::ST_OK : olle_pkg::ST_NOT_FOUND;
        end
        if (steps_r == ONE_CNT) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    steps_r <= steps_nxt;
    op_r    <= op_nxt;
    key_r   <= key_nxt;
    found_r <= found_nxt;
    oitem_r <= oitem_nxt;
    ostat_r <= ostat_nxt;
    olast_r <= olast_nxt;
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [olle_pkg::VAL_W-1:0] nbr;
    if (g == DEPTH - 1) begin : g_end
      assign nbr = cell_val[0];
    end else begin : g_mid
      assign nbr = cell_val[g+1];
    end
    olle_cell #(
      .DEPTH    (DEPTH),
      .CELL_IDX (g)
    ) u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .load_idx (count_r[IDX_W-1:0]),
      .tail_idx (tail_idx),
      .load_val (in_value),
      .next_val (nbr),
      .head_val (cell_val[0]),
      .val      (cell_val[g])
    );
  end

  assign busy           = (state_r == S_RUN);
  assign out_valid      = ovld_r;
  assign out_item_value = oitem_r;
  assign out_status     = ostat_r;
  assign out_last       = olast_r;

  `OLLE_ASSERT_IMP(a_full_count, ovld_r && (ostat_r == olle_pkg::ST_FULL), count_r == FULL_CNT)
  `OLLE_ASSERT_IMP(a_run_steps, state_r == S_RUN, (steps_r != '0) && (count_r != '0))
  `OLLE_ASSERT_IMP(a_err_last, ovld_r && (ostat_r != olle_pkg::ST_OK), olast_r)
  `OLLE_ASSERT_NXT(a_clear, accept && (func_in == olle_pkg::FN_CLEAR), count_r == '0)

endmodule

// ----- tb/tb_ordered_list_engine_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered list engine testbench
// Drives insert, delete, traverse and clear requests with bursty pacing and
// keeps a shadow copy of the list to work out every result beat. Each beat
// on the result port is compared field by field with the oldest one due.
// Directed requests cover the empty list, a full list, extreme values,
// duplicate values and misses; random requests follow.
// ----------------------------------------------------------------------------
module tb_ordered_list_engine_unit;

  localparam int DEPTH       = olle_pkg::DEPTH_DEF;
  localparam int IDX_W       = $clog2(DEPTH);
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_REQS = 430;

  typedef struct {
    logic [olle_pkg::VAL_W-1:0] item;
    olle_pkg::status_t          status;
    logic                       last;
  } list_beat_t;

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              start = 1'b0;
  logic [1:0]                        in_func = olle_pkg::FN_INSERT;
  logic signed [olle_pkg::VAL_W-1:0] in_value = '0;
  logic                              busy;
  logic                              out_valid;
  logic signed [olle_pkg::VAL_W-1:0] out_item_value;
  logic [1:0]                        out_status;
  logic                              out_last;

  logic [olle_pkg::VAL_W-1:0] shadow_vals [DEPTH];
  logic [$clog2(DEPTH):0]     shadow_count = '0;
  list_beat_t                 due_beats [$];
  int                         err_count = 0;
  int                         cycle_count = 0;
  int                         burst_left = 0;

  ordered_list_engine_unit #(.DEPTH(DEPTH)) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_func        (in_func),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_item_value (out_item_value),
    .out_status     (out_status),
    .out_last       (out_last)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic report_mismatch(string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    err_count++;
  endtask

  task automatic push_beat(logic [olle_pkg::VAL_W-1:0] item, olle_pkg::status_t status,
                           logic last);
    list_beat_t b;
    b.item = item;
    b.status = status;
    b.last = last;
    due_beats.push_back(b);
  endtask

  // shadow list update and expected beats for one accepted request
  task automatic apply_list_op(olle_pkg::func_t f, logic [olle_pkg::VAL_W-1:0] v);
    int hit;
    hit = -1;
    case (f)
      olle_pkg::FN_INSERT: begin
        if (shadow_count >= DEPTH) begin
          push_beat('0, olle_pkg::ST_FULL, 1'b1);
        end else begin
          shadow_vals[shadow_count[IDX_W-1:0]] = v;
          shadow_count++;
          push_beat('0, olle_pkg::ST_OK, 1'b1);
        end
      end
      olle_pkg::FN_DELETE: begin
        if (shadow_count == 0) begin
          push_beat('0, olle_pkg::ST_EMPTY, 1'b1);
        end else begin
          for (int i = 0; i < shadow_count; i++) begin
            if (hit < 0 && shadow_vals[i] == v) hit = i;
          end
          if (hit < 0) begin
            push_beat('0, olle_pkg::ST_NOT_FOUND, 1'b1);
          end else begin
            for (int i = hit; i + 1 < shadow_count; i++) shadow_vals[i] = shadow_vals[i+1];
            shadow_count--;
            push_beat('0, olle_pkg::ST_OK, 1'b1);
          end
        end
      end
      olle_pkg::FN_TRAVERSE: begin
        if (shadow_count == 0) begin
          push_beat('0, olle_pkg::ST_EMPTY, 1'b1);
        end else begin
          for (int i = 0; i < shadow_count; i++)
            push_beat(shadow_vals[i], olle_pkg::ST_OK, i + 1 == shadow_count);
        end
      end
      default: begin
        shadow_count = '0;
        push_beat('0, olle_pkg::ST_OK, 1'b1);
      end
    endcase
  endtask

  // one request beat; gaps may come between bursts
  task automatic send_request(olle_pkg::func_t f, logic [olle_pkg::VAL_W-1:0] v);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 2 * DEPTH)) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    start    <= 1'b1;
    in_func  <= f;
    in_value <= v;
    do @(posedge clk); while (busy !== 1'b0);
    apply_list_op(f, v);
  endtask

  function automatic logic [olle_pkg::VAL_W-1:0] pick_value();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 55) return $urandom;
    if (sel < 85) return $urandom_range(0, 7);
    case ($urandom_range(0, 3))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      default: return 32'hffff_ffff;
    endcase
  endfunction

  always @(posedge clk) begin : check_beats
    list_beat_t exp_beat;
    if (rst_n && out_valid !== 1'b0) begin
      if (due_beats.size() == 0) begin
        report_mismatch($sformatf("unexpected beat item=%h status=%0d last=%b",
                                  out_item_value, out_status, out_last));
      end else begin
        exp_beat = due_beats.pop_front();
        if (out_item_value !== exp_beat.item)
          report_mismatch($sformatf("item_value %h, expected %h",
                                    out_item_value, exp_beat.item));
        if (out_status !== exp_beat.status)
          report_mismatch($sformatf("status %0d, expected %s",
                                    out_status, exp_beat.status.name()));
        if (out_last !== exp_beat.last)
          report_mismatch($sformatf("last %b, expected %b", out_last, exp_beat.last));
      end
    end
  end

  task automatic test_empty_list();
    send_request(olle_pkg::FN_TRAVERSE, '0);
    send_request(olle_pkg::FN_DELETE, 32'd5);
    send_request(olle_pkg::FN_CLEAR, '0);
  endtask

  // fill to DEPTH with extremes and a duplicate of the head, then overflow
  task automatic test_fill_to_full();
    send_request(olle_pkg::FN_INSERT, 32'd7);
    send_request(olle_pkg::FN_INSERT, 32'h8000_0000);
    send_request(olle_pkg::FN_INSERT, 32'h7fff_ffff);
    send_request(olle_pkg::FN_INSERT, 32'h0000_0000);
    send_request(olle_pkg::FN_INSERT, 32'hffff_ffff);
    send_request(olle_pkg::FN_INSERT, 32'd7);
    for (int i = 6; i < DEPTH; i++) send_request(olle_pkg::FN_INSERT, 32'h1000_0000 + i);
    send_request(olle_pkg::FN_INSERT, 32'h5555_aaaa);
    send_request(olle_pkg::FN_TRAVERSE, '0);
  endtask

  task automatic test_delete_cases();
    send_request(olle_pkg::FN_DELETE, 32'h1234_5678);
    send_request(olle_pkg::FN_DELETE, 32'd7);
    send_request(olle_pkg::FN_DELETE, 32'h1000_0000 + DEPTH - 1);
    send_request(olle_pkg::FN_TRAVERSE, '0);
    send_request(olle_pkg::FN_CLEAR, '0);
  endtask

  task automatic test_random_ops(int n);
    int sel;
    for (int k = 0; k < n; k++) begin
      sel = $urandom_range(0, 99);
      if (sel < 45) begin
        send_request(olle_pkg::FN_INSERT, pick_value());
      end else if (sel < 75) begin
        if (shadow_count > 0 && $urandom_range(0, 99) < 80)
          send_request(olle_pkg::FN_DELETE,
                       shadow_vals[$urandom_range(0, shadow_count - 1)]);
        else
          send_request(olle_pkg::FN_DELETE, pick_value());
      end else if (sel < 95) begin
        send_request(olle_pkg::FN_TRAVERSE, $urandom);
      end else begin
        send_request(olle_pkg::FN_CLEAR, $urandom);
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_list();
    test_fill_to_full();
    test_delete_cases();
    test_random_ops(RANDOM_REQS);
    start <= 1'b0;
    while (due_beats.size() != 0) @(posedge clk);
    repeat (DEPTH + 4) @(posedge clk);
    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
